@@ design/pcpe_pkg.sv @@
// pcpe_pkg: shared constants and types for the parallel curve point evaluator
// no dependencies; imported by pcpe_exp, parallel_curve_point_eval_top and the testbench

package pcpe_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE_POS = 2'd0;
  localparam logic [1:0] CFG_ACCEL    = 2'd1;
  localparam logic [1:0] CFG_TSHIFT   = 2'd2;

  // configuration reset values
  localparam logic [30:0] BASE_POS_RST = 31'd42607418;
  localparam logic [30:0] ACCEL_RST    = 31'd786684;
  localparam logic [31:0] TSHIFT_RST   = 32'd1090519040;

  localparam logic [31:0] I32_MAX_C = 32'h7FFF_FFFF;
  localparam logic [31:0] I32_MIN_C = 32'h8000_0000;

  // exp unit constants (series in q30)
  localparam logic [31:0] Q30_ONE   = 32'd1073741824;
  localparam logic [36:0] LN2_Q30   = 37'd744261118;
  // 94 * ln2 in q30, lifts the most negative reduced argument above zero
  localparam int          K_BIAS    = 94;
  localparam logic signed [37:0] LN2_OFF = 38'sd69960545092;
  localparam int          EXP_TERMS = 12;
  localparam int          EXP_IN_W  = 34;
  localparam int          EXP_LAT   = 33;

  typedef enum logic [1:0] {
    EXP_NORMAL,
    EXP_OVF,
    EXP_UNDER
  } exp_mode_t;

endpackage

@@ design/pcpe_dly.sv @@
// pcpe_dly: fixed-depth register delay line for side data of the pipeline
// no dependencies

module pcpe_dly #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] pipe_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    pipe_r[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign d_o = pipe_r[DEPTH-1];

endmodule

@@ design/pcpe_div.sv @@
// pcpe_div: pipelined restoring divider, one quotient bit per stage
// signed dividend, positive divisor, quotient truncated toward zero; no dependencies

module pcpe_div #(
  parameter int MAG_W = 56,
  parameter int DVS_W = 31
) (
  input  logic                    clk,
  input  logic signed [MAG_W:0]   dvd_i,
  input  logic [DVS_W-1:0]        dvs_i,
  output logic signed [MAG_W:0]   quo_o
);

  logic [DVS_W-1:0] rem_r [0:MAG_W];
  logic [MAG_W-1:0] dq_r  [0:MAG_W];
  logic [DVS_W-1:0] dvs_r [0:MAG_W];
  logic             neg_r [0:MAG_W];
  logic signed [MAG_W:0] quo_r;
  logic [MAG_W:0]   neg_dvd;

  assign neg_dvd = -dvd_i;

  always_ff @(posedge clk) begin
    neg_r[0] <= dvd_i[MAG_W];
    dq_r[0]  <= dvd_i[MAG_W] ? neg_dvd[MAG_W-1:0] : dvd_i[MAG_W-1:0];
    rem_r[0] <= '0;
    dvs_r[0] <= dvs_i;
  end

  for (genvar i = 1; i <= MAG_W; i++) begin : g_step
    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;
    assign trial = {rem_r[i-1], dq_r[i-1][MAG_W-1]};
    assign diff  = trial - {1'b0, dvs_r[i-1]};
    assign ge    = trial >= {1'b0, dvs_r[i-1]};
    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dq_r[i]  <= {dq_r[i-1][MAG_W-2:0], ge};
      dvs_r[i] <= dvs_r[i-1];
      neg_r[i] <= neg_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (neg_r[MAG_W]) begin
      quo_r <= -$signed({1'b0, dq_r[MAG_W]});
    end else begin
      quo_r <= $signed({1'b0, dq_r[MAG_W]});
    end
  end

  assign quo_o = quo_r;

endmodule

@@ design/pcpe_exp.sv @@
// pcpe_exp: pipelined fixed-point exp (ln2 range reduction, 12-term q30 series)
// depends on pcpe_pkg; one item per cycle

module pcpe_exp #(
  parameter int FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic signed [pcpe_pkg::EXP_IN_W-1:0] x_i,
  output logic [31:0]                         exp_o,
  output logic                                ovf_o
);

  import pcpe_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int DIV_STEPS = 8;
  localparam int NSER = EXP_TERMS - 1;
  localparam logic signed [37:0] X_HI = 38'sd32 <<< F;
  localparam logic signed [37:0] X_LO = -(38'sd64 <<< F);
  localparam logic signed [9:0]  SH0 = 10'(30 - F + K_BIAS);

  typedef struct packed {
    exp_mode_t   mode;
    logic [7:0]  quo;
    logic [29:0] r;
    logic [31:0] sum;
  } ser_side_t;

  // range check and offset into a nonnegative dividend
  logic signed [37:0] xw, xq, u_c;
  exp_mode_t          mode_c;

  assign xw  = $signed({{(38-EXP_IN_W){x_i[EXP_IN_W-1]}}, x_i});
  assign xq  = xw <<< (30 - F);
  assign u_c = xq + LN2_OFF;

  always_comb begin
    if (xw > X_HI) begin
      mode_c = EXP_OVF;
    end else if (xw < X_LO) begin
      mode_c = EXP_UNDER;
    end else begin
      mode_c = EXP_NORMAL;
    end
  end

  logic [36:0] val_r  [0:DIV_STEPS];
  logic [7:0]  quo_r  [0:DIV_STEPS];
  exp_mode_t   dmode_r[0:DIV_STEPS];

  always_ff @(posedge clk) begin
    val_r[0]   <= (mode_c == EXP_NORMAL) ? u_c[36:0] : '0;
    quo_r[0]   <= '0;
    dmode_r[0] <= mode_c;
  end

  // divide by ln2, one quotient bit per stage
  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_red
    localparam logic [36:0] LN2_SH = LN2_Q30 << (DIV_STEPS - i);
    always_ff @(posedge clk) begin
      dmode_r[i] <= dmode_r[i-1];
      if (val_r[i-1] >= LN2_SH) begin
        val_r[i] <= val_r[i-1] - LN2_SH;
        quo_r[i] <= {quo_r[i-1][6:0], 1'b1};
      end else begin
        val_r[i] <= val_r[i-1];
        quo_r[i] <= {quo_r[i-1][6:0], 1'b0};
      end
    end
  end

  // series: first term is r itself, then two stages per further term
  logic [29:0] va_r [0:NSER-1];
  ser_side_t   sa_r [0:NSER-1];
  logic [29:0] tb_r [0:NSER-1];
  ser_side_t   sb_r [0:NSER-1];

  for (genvar m = 0; m < NSER; m++) begin : g_ser
    localparam int N  = m + 2;
    localparam int SH = 30 + $clog2(N);
    localparam logic [63:0] MR = ((64'd1 << SH) + 64'(N) - 64'd1) / 64'(N);
    logic [29:0] term_in;
    ser_side_t   side_in;
    logic [59:0] tp;
    logic [60:0] qp;
    if (m == 0) begin : g_first
      assign term_in = val_r[DIV_STEPS][29:0];
      assign side_in = {dmode_r[DIV_STEPS], quo_r[DIV_STEPS], val_r[DIV_STEPS][29:0],
                        Q30_ONE};
    end else begin : g_next
      assign term_in = tb_r[m-1];
      assign side_in = sb_r[m-1];
    end
    assign tp = 60'(term_in) * 60'(side_in.r);
    assign qp = 61'(va_r[m]) * 61'(MR[30:0]);
    always_ff @(posedge clk) begin
      va_r[m]      <= tp[59:30];
      sa_r[m].mode <= side_in.mode;
      sa_r[m].quo  <= side_in.quo;
      sa_r[m].r    <= side_in.r;
      sa_r[m].sum  <= side_in.sum + 32'(term_in);
      tb_r[m]      <= 30'(qp >> SH);
      sb_r[m]      <= sa_r[m];
    end
  end

  ser_side_t sf_r;
  always_ff @(posedge clk) begin
    sf_r.mode <= sb_r[NSER-1].mode;
    sf_r.quo  <= sb_r[NSER-1].quo;
    sf_r.r    <= sb_r[NSER-1].r;
    sf_r.sum  <= sb_r[NSER-1].sum + 32'(tb_r[NSER-1]);
  end

  // scale by 2^k back to the output format
  logic signed [9:0] sh;
  logic [31:0]       shv;
  logic [31:0]       ex_r;
  logic              ovf_r;

  assign sh  = SH0 - $signed({2'b00, sf_r.quo});
  assign shv = sf_r.sum >> sh[4:0];

  always_ff @(posedge clk) begin
    case (sf_r.mode)
      EXP_OVF: begin
        ex_r  <= I32_MAX_C;
        ovf_r <= 1'b1;
      end
      EXP_UNDER: begin
        ex_r  <= '0;
        ovf_r <= 1'b0;
      end
      default: begin
        if (sh[9]) begin
          ex_r  <= I32_MAX_C;
          ovf_r <= 1'b1;
        end else if (sh >= 10'sd32) begin
          ex_r  <= '0;
          ovf_r <= 1'b0;
        end else if (shv[31]) begin
          ex_r  <= I32_MAX_C;
          ovf_r <= 1'b1;
        end else begin
          ex_r  <= shv;
          ovf_r <= 1'b0;
        end
      end
    endcase
  end

  assign exp_o = ex_r;
  assign ovf_o = ovf_r;

endmodule

@@ design/parallel_curve_point_eval_top.sv @@
// parallel_curve_point_eval_top: one curve coordinate per item, p*exp(s/(p*e^d)+d-nu*t/p)
// depends on pcpe_pkg, pcpe_exp, pcpe_div and pcpe_dly
// throughput: one item per cycle, busy stays low; the two dividers and exp units set depth
// results appear for one cycle on out_strobe and the receiver cannot stall them
// reset clears the valid pipeline and loads the config defaults; data regs are not reset

module parallel_curve_point_eval_top #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_delta_val,
  input  logic signed [31:0] in_nu_val,
  input  logic signed [31:0] in_space_shift,
  input  logic signed [31:0] in_age,
  output logic               out_strobe,
  output logic signed [31:0] out_curve_value,
  output logic               out_saturated,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  import pcpe_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int MW1    = 32 + F;
  localparam int LD1    = MW1 + 2;
  localparam int MW2    = 63;
  localparam int LD2    = MW2 + 2;
  localparam int TA     = EXP_LAT + 3 + LD1;
  localparam int TB     = 5 + LD2;
  localparam int OUT_ST = TA + EXP_LAT + 3;

  function automatic logic signed [33:0] sx34(input logic [31:0] v);
    return $signed({{2{v[31]}}, v});
  endfunction

  // configuration
  logic [30:0]        pos_r, acc_r;
  logic signed [31:0] tau_r;
  logic [30:0]        p_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= BASE_POS_RST;
      acc_r <= ACCEL_RST;
      tau_r <= TSHIFT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BASE_POS: pos_r <= cfg_wdata[30:0];
        CFG_ACCEL:    acc_r <= cfg_wdata[30:0];
        CFG_TSHIFT:   tau_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign p_eff = (pos_r == '0) ? 31'd1 : pos_r;
  assign busy  = 1'b0;

  // valid bits travel alongside the data stages
  logic [OUT_ST:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[OUT_ST-1:0], start};
    end
  end

  logic signed [31:0] d0_r, nu0_r, s0_r, age0_r;
  always_ff @(posedge clk) begin
    d0_r   <= in_delta_val;
    nu0_r  <= in_nu_val;
    s0_r   <= in_space_shift;
    age0_r <= in_age;
  end

  // time branch: t = acc*(age-tau), then nu*t/p
  logic signed [32:0] diff1_r;
  logic signed [64:0] prod2_r;
  logic signed [64:0] tsh;
  logic               t_inr;
  logic signed [31:0] t3_r;
  logic               ft3_r;
  logic [31:0]        nu3;
  logic signed [63:0] nt4_r;
  logic signed [63:0] q2;
  logic               ft_d;
  logic               q2_inr;
  logic signed [31:0] term_r;
  logic               fb_r;
  logic [32:0]        tb_d;

  assign tsh   = prod2_r >>> F;
  assign t_inr = (&tsh[64:31]) | ~(|tsh[64:31]);

  pcpe_dly #(.W(32), .DEPTH(3)) u_dly_nu (.clk(clk), .d_i(nu0_r), .d_o(nu3));

  always_ff @(posedge clk) begin
    diff1_r <= $signed({age0_r[31], age0_r}) - $signed({tau_r[31], tau_r});
    prod2_r <= $signed({1'b0, acc_r}) * diff1_r;
    t3_r    <= t_inr ? tsh[31:0] : (tsh[64] ? I32_MIN_C : I32_MAX_C);
    ft3_r   <= ~t_inr;
    nt4_r   <= $signed(nu3) * t3_r;
  end

  pcpe_div #(.MAG_W(MW2), .DVS_W(31)) u_div_term (
    .clk(clk), .dvd_i(nt4_r), .dvs_i(p_eff), .quo_o(q2)
  );

  pcpe_dly #(.W(1), .DEPTH(TB-4)) u_dly_ft (.clk(clk), .d_i(ft3_r), .d_o(ft_d));

  assign q2_inr = (&q2[63:31]) | ~(|q2[63:31]);

  always_ff @(posedge clk) begin
    term_r <= q2_inr ? q2[31:0] : (q2[63] ? I32_MIN_C : I32_MAX_C);
    fb_r   <= ft_d | ~q2_inr;
  end

  pcpe_dly #(.W(33), .DEPTH(TA-TB)) u_dly_term (
    .clk(clk), .d_i({fb_r, term_r}), .d_o(tb_d)
  );

  // space branch: den = p*exp(d), q = s/den
  logic [31:0]        ed1;
  logic               fe1;
  logic [61:0]        dprod_r;
  logic               fa1_r;
  logic [61:0]        dsh;
  logic               dovf;
  logic [30:0]        den_c;
  logic [30:0]        den_r;
  logic               fa2_r;
  logic [31:0]        s_d;
  logic signed [MW1:0] q1;
  logic               fa_d;
  logic               q1_inr;
  logic signed [31:0] qa_r;
  logic               fa_r;
  logic [31:0]        d_d;

  pcpe_exp #(.FRAC_BITS(F)) u_exp_d (
    .clk(clk), .x_i(sx34(d0_r)), .exp_o(ed1), .ovf_o(fe1)
  );

  assign dsh   = dprod_r >> F;
  assign dovf  = |dsh[61:31];
  assign den_c = dovf ? I32_MAX_C[30:0] : dsh[30:0];

  always_ff @(posedge clk) begin
    dprod_r <= 62'(p_eff) * 62'(ed1[30:0]);
    fa1_r   <= fe1;
    // a vanishing divisor falls back to one step
    den_r   <= (den_c == '0) ? 31'd1 : den_c;
    fa2_r   <= fa1_r | dovf;
  end

  pcpe_dly #(.W(32), .DEPTH(EXP_LAT+2)) u_dly_s (.clk(clk), .d_i(s0_r), .d_o(s_d));

  pcpe_div #(.MAG_W(MW1), .DVS_W(31)) u_div_q (
    .clk(clk), .dvd_i($signed({s_d[31], s_d, {F{1'b0}}})), .dvs_i(den_r), .quo_o(q1)
  );

  pcpe_dly #(.W(1), .DEPTH(LD1)) u_dly_fa (.clk(clk), .d_i(fa2_r), .d_o(fa_d));

  assign q1_inr = (&q1[MW1:31]) | ~(|q1[MW1:31]);

  always_ff @(posedge clk) begin
    qa_r <= q1_inr ? q1[31:0] : (q1[MW1] ? I32_MIN_C : I32_MAX_C);
    fa_r <= fa_d | ~q1_inr;
  end

  pcpe_dly #(.W(32), .DEPTH(TA)) u_dly_d (.clk(clk), .d_i(d0_r), .d_o(d_d));

  // merge, second exp and final scaling
  logic signed [33:0] arg_r;
  logic               fm_r;
  logic [31:0]        ex2;
  logic               fe2;
  logic               fm_d;
  logic [61:0]        rprod_r;
  logic               fr1_r;
  logic [61:0]        rsh;
  logic               rovf;
  logic signed [31:0] res_r;
  logic               sat_r;

  always_ff @(posedge clk) begin
    arg_r <= sx34(qa_r) + sx34(d_d) - sx34(tb_d[31:0]);
    fm_r  <= fa_r | tb_d[32];
  end

  pcpe_exp #(.FRAC_BITS(F)) u_exp_arg (
    .clk(clk), .x_i(arg_r), .exp_o(ex2), .ovf_o(fe2)
  );

  pcpe_dly #(.W(1), .DEPTH(EXP_LAT)) u_dly_fm (.clk(clk), .d_i(fm_r), .d_o(fm_d));

  assign rsh  = rprod_r >> F;
  assign rovf = |rsh[61:31];

  always_ff @(posedge clk) begin
    rprod_r <= 62'(p_eff) * 62'(ex2[30:0]);
    fr1_r   <= fm_d | fe2;
    res_r   <= rovf ? I32_MAX_C : {1'b0, rsh[30:0]};
    sat_r   <= fr1_r | rovf;
  end

  assign out_strobe      = vld_r[OUT_ST];
  assign out_curve_value = res_r;
  assign out_saturated   = sat_r;

endmodule

@@ tb/sv/testbench.sv @@
// testbench for parallel_curve_point_eval_top: drives items and config writes,
// predicts each curve value in a scoreboard class; depends on pcpe_pkg and the rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pcpe_pkg::*;

  localparam int FB = 24;
  localparam int PIPE_LAT = 106 + FB;
  localparam longint I32MAX = 64'sd2147483647;
  localparam longint I32MIN = -64'sd2147483648;
  localparam longint LN2Q = 64'sd744261118;

  typedef struct {
    logic signed [31:0] curve;
    logic               sat;
  } curve_res_t;

  class curve_scoreboard;
    longint pos_q, accel_q, shift_q;
    curve_res_t pending[$];
    int errors;
    int checked;

    function new();
      pos_q = BASE_POS_RST;
      accel_q = ACCEL_RST;
      shift_q = longint'($signed(TSHIFT_RST));
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_BASE_POS: pos_q = val[30:0];
        CFG_ACCEL:    accel_q = val[30:0];
        CFG_TSHIFT:   shift_q = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function longint clip(longint x, inout bit fl);
      if (x > I32MAX) begin
        fl = 1;
        return I32MAX;
      end
      if (x < I32MIN) begin
        fl = 1;
        return I32MIN;
      end
      return x;
    endfunction

    function longint fx_exp(longint x, inout bit fl);
      longint xq, k, r, sh;
      longint unsigned sum, term;
      if (x > (64'sd32 <<< FB)) begin
        fl = 1;
        return I32MAX;
      end
      if (x < -(64'sd64 <<< FB)) return 0;
      xq = x * (64'sd1 <<< (30 - FB));
      k = xq / LN2Q;
      r = xq - k * LN2Q;
      if (r < 0) begin
        k -= 1;
        r += LN2Q;
      end
      sum = 64'd1073741824;
      term = sum;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * longint'(r)) >> 30) / n;
        sum += term;
      end
      sh = k + FB - 30;
      if (sh > 0) begin
        fl = 1;
        return I32MAX;
      end
      if (sh < 0) begin
        if (-sh >= 63) return 0;
        sum = sum >> (-sh);
      end
      if (sum > 64'd2147483647) begin
        fl = 1;
        return I32MAX;
      end
      return longint'(sum);
    endfunction

    function void note_item(logic signed [31:0] d32, nu32, s32, age32);
      bit fl;
      longint p, d, nu, s, t, ed, den, q, tm, ex, res;
      curve_res_t e;
      fl = 0;
      d = d32; nu = nu32; s = s32;
      p = (pos_q == 0) ? 1 : pos_q;
      // arithmetic shift is floor rounding
      t = clip((accel_q * (longint'(age32) - shift_q)) >>> FB, fl);
      ed = fx_exp(d, fl);
      den = clip((p * ed) >>> FB, fl);
      if (den == 0) den = 1;
      q = clip((s * (64'sd1 <<< FB)) / den, fl);
      tm = clip((nu * t) / p, fl);
      ex = fx_exp(q + d - tm, fl);
      res = clip((p * ex) >>> FB, fl);
      e.curve = res[31:0];
      e.sat = fl;
      pending = {pending, e};
    endfunction

    function void check_result(logic signed [31:0] cv, logic sat);
      curve_res_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result curve=%0d sat=%0b", $time, cv, sat);
        return;
      end
      e = pending.pop_front();
      if (cv !== e.curve) begin
        errors++;
        $display("%0t: curve_value expected %0d actual %0d", $time, e.curve, cv);
      end
      if (sat !== e.sat) begin
        errors++;
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] in_delta_val = 0, in_nu_val = 0, in_space_shift = 0, in_age = 0;
  logic out_strobe;
  logic signed [31:0] out_curve_value;
  logic out_saturated;
  logic cfg_wr_en = 0;
  logic [1:0] cfg_index = CFG_BASE_POS;
  logic [31:0] cfg_wdata = 0;

  curve_scoreboard sb = new();
  longint cycles = 0;
  int items_sent = 0;

  parallel_curve_point_eval_top #(.FRAC_BITS(FB)) u_top (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) sb.check_result(out_curve_value, out_saturated);
    if (rst_n && start && !busy) begin
      sb.note_item(in_delta_val, in_nu_val, in_space_shift, in_age);
      items_sent <= items_sent + 1;
    end
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_item(logic signed [31:0] d, nu, s, a);
    start <= 1;
    in_delta_val <= d;
    in_nu_val <= nu;
    in_space_shift <= s;
    in_age <= a;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 40);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  // values mostly near the useful range so exp is neither flat nor clamped
  function automatic logic signed [31:0] rnd_q(int span_bits);
    logic signed [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 9) < 8) v = v >>> (31 - span_bits);
    return v;
  endfunction

  logic signed [31:0] corner[8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1,
                                   32'sh0100_0000, -32'sh0100_0000, 32'sh2000_0000};

  initial begin
    logic [31:0] pos_set[5] = '{32'd0, 32'h7FFF_FFFF, 32'd16777216, 32'd1, 32'd42607418};
    logic [31:0] acc_set[5] = '{32'd0, 32'h7FFF_FFFF, 32'd16777216, 32'd786684, 32'd3000000};
    logic [31:0] sh_set[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1090519040,
                               32'd1258291200};
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: field extremes and special cases at reset config
    for (int i = 0; i < 8; i++)
      send_item(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8], corner[(i + 1) % 8]);
    send_item(32'sh2100_0000, 0, 0, 32'sh4100_0000);   // exp argument above 32
    send_item(-32'sh4100_0000, 0, 0, 32'sh4100_0000);  // tiny divisor
    send_item(0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000);   // huge positive exponent
    send_item(0, 32'sh0100_0000, 32'sh0080_0000, 32'sh4800_0000);
    drain();
    write_cfg(CFG_BASE_POS, 32'd0);  // zero position acts as one
    send_item(0, 0, 0, 0);
    send_item(corner[0], 0, corner[1], 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(CFG_BASE_POS, pos_set[ph]);
      write_cfg(CFG_ACCEL, acc_set[ph]);
      write_cfg(CFG_TSHIFT, sh_set[ph]);
      for (int n = 0; n < 390; n++) begin
        send_item(rnd_q(27), rnd_q(26), rnd_q(27), rnd_q(30));
        idle_gap();
      end
      drain();
    end

    $display("covered %0d items over 7 config settings, %0d results checked",
             items_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/pcpe_pkg.sv
design/pcpe_dly.sv
design/pcpe_div.sv
design/pcpe_exp.sv
design/parallel_curve_point_eval_top.sv
tb/sv/testbench.sv
